@@ hw/rtl/ihcs_pkg.sv @@
// ----------------------------------------------------------------------------
// ihcs_pkg
// Shared types, register map, and micro-program for the IHC synapse step.
// ----------------------------------------------------------------------------
package ihcs_pkg;

    localparam int FRAC     = 24;
    localparam int PADDR_W  = 6;
    localparam int PDATA_W  = 64;
    localparam int CHAN_W   = 4;
    localparam int SAMPLE_W = 32;
    localparam int VOL_W    = 47;
    localparam int CONC_W   = 48;
    localparam int PROB_W   = 48;

    typedef enum logic [2:0] {
        REG_GAIN   = 3'd0,
        REG_REST   = 3'd1,
        REG_SPAN_I = 3'd2,
        REG_SPAN_L = 3'd3,
        REG_SPAN_G = 3'd4,
        REG_GCONC  = 3'd5,
        REG_VMAX_I = 3'd6,
        REG_VMAX_L = 3'd7
    } t_reg_idx;

    typedef enum logic [2:0] {
        OP_MUL  = 3'd0,
        OP_DIV  = 3'd1,
        OP_ADD  = 3'd2,
        OP_SUB  = 3'd3,
        OP_ADDF = 3'd4
    } t_op;

    typedef enum logic [4:0] {
        SRC_ZERO, SRC_SAMPLE, SRC_GAIN, SRC_REST, SRC_SPAN_I, SRC_SPAN_L, SRC_SPAN_G,
        SRC_GCONC, SRC_VMAX_I, SRC_VMAX_L, SRC_RP, SRC_PI, SRC_PL, SRC_PG, SRC_VI,
        SRC_VL, SRC_CI, SRC_CL, SRC_T1, SRC_T2
    } t_src;

    typedef enum logic [3:0] {
        DST_RP, DST_PI, DST_PL, DST_PG, DST_VI, DST_VL, DST_CI, DST_CL, DST_T1, DST_T2
    } t_dst;

    typedef struct packed {
        t_op  op;
        t_src a;
        t_src b;
        t_dst dst;
    } t_uop;

    localparam int NSTEPS = 28;
    typedef logic [4:0] t_step;
    localparam t_step LAST_STEP = t_step'(NSTEPS - 1);

    // One Euler step, in order; the local update sees the new immediate conc.
    localparam t_uop UPROG [NSTEPS] = '{
        '{OP_MUL,  SRC_SAMPLE, SRC_GAIN,   DST_RP},
        '{OP_MUL,  SRC_SPAN_I, SRC_RP,     DST_T1},
        '{OP_ADDF, SRC_T1,     SRC_REST,   DST_PI},
        '{OP_MUL,  SRC_SPAN_L, SRC_RP,     DST_T1},
        '{OP_ADDF, SRC_T1,     SRC_REST,   DST_PL},
        '{OP_MUL,  SRC_SPAN_G, SRC_RP,     DST_T1},
        '{OP_ADDF, SRC_T1,     SRC_REST,   DST_PG},
        '{OP_ADDF, SRC_RP,     SRC_ZERO,   DST_RP},
        '{OP_SUB,  SRC_VMAX_I, SRC_VI,     DST_T1},
        '{OP_MUL,  SRC_T1,     SRC_RP,     DST_T1},
        '{OP_ADD,  SRC_VI,     SRC_T1,     DST_VI},
        '{OP_SUB,  SRC_VMAX_L, SRC_VL,     DST_T1},
        '{OP_MUL,  SRC_T1,     SRC_RP,     DST_T1},
        '{OP_ADD,  SRC_VL,     SRC_T1,     DST_VL},
        '{OP_SUB,  SRC_CL,     SRC_CI,     DST_T1},
        '{OP_MUL,  SRC_PL,     SRC_T1,     DST_T1},
        '{OP_MUL,  SRC_PI,     SRC_CI,     DST_T2},
        '{OP_SUB,  SRC_T1,     SRC_T2,     DST_T1},
        '{OP_DIV,  SRC_T1,     SRC_VI,     DST_T1},
        '{OP_ADD,  SRC_CI,     SRC_T1,     DST_CI},
        '{OP_SUB,  SRC_GCONC,  SRC_CL,     DST_T1},
        '{OP_MUL,  SRC_PG,     SRC_T1,     DST_T1},
        '{OP_SUB,  SRC_CL,     SRC_CI,     DST_T2},
        '{OP_MUL,  SRC_PL,     SRC_T2,     DST_T2},
        '{OP_SUB,  SRC_T1,     SRC_T2,     DST_T1},
        '{OP_DIV,  SRC_T1,     SRC_VL,     DST_T1},
        '{OP_ADD,  SRC_CL,     SRC_T1,     DST_CL},
        '{OP_MUL,  SRC_CI,     SRC_PI,     DST_T1}
    };

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FETCH = 5'b00010,
        S_EXEC  = 5'b00100,
        S_WAIT  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

endpackage

@@ hw/rtl/ihcs_mul.sv @@
// ----------------------------------------------------------------------------
// ihcs_mul
// Bit-serial fixed-point multiplier, truncating shift and saturation.
// ----------------------------------------------------------------------------
module ihcs_mul import ihcs_pkg::*; #(
    parameter int AW = 48,
    parameter int W  = 48
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [AW-1:0] i_a,
    input  logic signed [AW-1:0] i_b,
    output logic                 o_done,
    output logic        [W-1:0]  o_res
);

    localparam int CNTW = $clog2(AW + 1);

    logic [AW-1:0]   r_x;
    logic [AW-1:0]   r_y;
    logic [2*AW-1:0] r_acc;
    logic            r_neg;
    logic [CNTW-1:0] r_cnt;
    logic            r_fin;

    logic [AW:0]     n_sum;
    logic            w_over;
    logic [W-2:0]    w_mag;

    assign n_sum = {1'b0, r_acc[2*AW-1:AW]} + {1'b0, (r_y[0] ? r_x : '0)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_fin <= 1'b0;
        end else begin
            r_fin <= (r_cnt == CNTW'(1));
            if (i_start) begin
                r_cnt <= CNTW'(AW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNTW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_a[AW-1] ? AW'(-i_a) : AW'(i_a);
            r_y   <= i_b[AW-1] ? AW'(-i_b) : AW'(i_b);
            r_acc <= '0;
            r_neg <= i_a[AW-1] ^ i_b[AW-1];
        end else if (r_cnt != '0) begin
            r_acc <= {n_sum, r_acc[AW-1:1]};
            r_y   <= r_y >> 1;
        end
    end

    assign w_over = |r_acc[2*AW-1:FRAC+W-1];
    assign w_mag  = r_acc[FRAC+W-2:FRAC];

    always_comb begin
        if (r_neg) begin
            o_res = w_over ? {1'b1, {(W-1){1'b0}}} : W'(-{1'b0, w_mag});
        end else begin
            o_res = w_over ? {1'b0, {(W-1){1'b1}}} : {1'b0, w_mag};
        end
    end

    assign o_done = r_fin;

endmodule

@@ hw/rtl/ihcs_div.sv @@
// ----------------------------------------------------------------------------
// ihcs_div
// Bit-serial restoring divider for (n << FRAC) / d with saturation.
// ----------------------------------------------------------------------------
module ihcs_div import ihcs_pkg::*; #(
    parameter int AW = 48,
    parameter int W  = 48
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [AW-1:0] i_n,
    input  logic signed [AW-1:0] i_d,
    output logic                 o_done,
    output logic        [W-1:0]  o_res
);

    localparam int DQW  = AW + FRAC;
    localparam int CNTW = $clog2(DQW + 1);

    logic [DQW-1:0]  r_dq;
    logic [AW-1:0]   r_dm;
    logic [AW-1:0]   r_rem;
    logic            r_neg;
    logic            r_nzero;
    logic [CNTW-1:0] r_cnt;
    logic            r_fin;

    logic [AW:0]     w_rs;
    logic            w_ge;
    logic            w_over;

    assign w_rs = {r_rem, r_dq[DQW-1]};
    assign w_ge = (w_rs >= {1'b0, r_dm});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_fin <= 1'b0;
        end else begin
            r_fin <= (r_cnt == CNTW'(1));
            if (i_start) begin
                r_cnt <= CNTW'(DQW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNTW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dq    <= {(i_n[AW-1] ? AW'(-i_n) : AW'(i_n)), {FRAC{1'b0}}};
            r_dm    <= i_d[AW-1] ? AW'(-i_d) : AW'(i_d);
            r_rem   <= '0;
            r_neg   <= i_n[AW-1] ^ i_d[AW-1];
            r_nzero <= (i_n == '0);
        end else if (r_cnt != '0) begin
            r_rem <= AW'(w_ge ? (w_rs - {1'b0, r_dm}) : w_rs);
            r_dq  <= {r_dq[DQW-2:0], w_ge};
        end
    end

    // Zero divisor drives the quotient to all ones, which saturates by sign.
    assign w_over = |r_dq[DQW-1:W-1];

    always_comb begin
        if (r_nzero) begin
            o_res = '0;
        end else if (r_neg) begin
            o_res = w_over ? {1'b1, {(W-1){1'b0}}} : W'(-{1'b0, r_dq[W-2:0]});
        end else begin
            o_res = w_over ? {1'b0, {(W-1){1'b1}}} : {1'b0, r_dq[W-2:0]};
        end
    end

    assign o_done = r_fin;

endmodule

@@ hw/rtl/ihc_synapse_reservoir_step_top.sv @@
// ----------------------------------------------------------------------------
// ihc_synapse_reservoir_step_top
// Inner-hair-cell synapse, three-reservoir Euler step per sample and channel.
// ----------------------------------------------------------------------------
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+-------------------------------------
//  request  | i_in_valid / o_in_stall    | i_func, i_channel, i_sample, i_init_*
//  result   | o_out_valid / i_out_stall  | o_out_channel, o_spike_prob
//  config   | psel, penable, pwrite      | paddr (8*index), pwdata, prdata
//
//  A sample request holds o_in_stall high until its result enters the output
//  register, so no new request is taken meanwhile. The 11 products go through
//  one bit-serial multiplier and the 2 quotients through one bit-serial
//  divider, both AW = max(DATA_WIDTH, 48) bits wide, one bit per cycle each.
//  A load request writes its channel store when taken; a request for a
//  channel beyond NUM_CHANNELS is dropped.
//  Reset is synchronous and active low; channel stores hold garbage until a
//  load request writes them.
//  The output register frees the request side: a new request is taken while
//  the previous result still waits on i_out_stall.
// ----------------------------------------------------------------------------
module ihc_synapse_reservoir_step_top import ihcs_pkg::*; #(
    parameter int NUM_CHANNELS = 16,
    parameter int DATA_WIDTH   = 48
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // request channel
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_func,
    input  logic        [CHAN_W-1:0]   i_channel,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic        [VOL_W-1:0]    i_init_immediate_volume,
    input  logic        [VOL_W-1:0]    i_init_local_volume,
    input  logic signed [CONC_W-1:0]   i_init_immediate_conc,
    input  logic signed [CONC_W-1:0]   i_init_local_conc,
    // result channel
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic        [CHAN_W-1:0]   o_out_channel,
    output logic signed [PROB_W-1:0]   o_spike_prob,
    // configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic        [PADDR_W-1:0]  paddr,
    input  logic        [PDATA_W-1:0]  pwdata,
    output logic        [PDATA_W-1:0]  prdata,
    output logic                       pready
);

    localparam int W  = DATA_WIDTH;
    localparam int AW = (DATA_WIDTH > 48) ? DATA_WIDTH : 48;
    localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    localparam logic signed [AW:0] MAXW  = {{(AW-W+2){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [AW:0] MINW  = {{(AW-W+2){1'b1}}, {(W-1){1'b0}}};
    localparam logic signed [AW:0] MAXP  = {{(AW-PROB_W+2){1'b0}}, {(PROB_W-1){1'b1}}};
    localparam logic signed [AW:0] MINP  = {{(AW-PROB_W+2){1'b1}}, {(PROB_W-1){1'b0}}};

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [47:0]      r_gain;
    logic [VOL_W-1:0] r_rest;
    logic [47:0]      r_span_i;
    logic [47:0]      r_span_l;
    logic [47:0]      r_span_g;
    logic [VOL_W-1:0] r_gconc;
    logic [VOL_W-1:0] r_vmax_i;
    logic [VOL_W-1:0] r_vmax_l;

    t_reg_idx w_reg;
    assign w_reg  = t_reg_idx'(paddr[5:3]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= 48'd16777216;
            r_rest   <= '0;
            r_span_i <= '0;
            r_span_l <= '0;
            r_span_g <= '0;
            r_gconc  <= '0;
            r_vmax_i <= VOL_W'(16777216);
            r_vmax_l <= VOL_W'(16777216);
        end else if (psel && penable && pwrite && pready) begin
            unique case (w_reg)
                REG_GAIN:   r_gain   <= pwdata[47:0];
                REG_REST:   r_rest   <= pwdata[VOL_W-1:0];
                REG_SPAN_I: r_span_i <= pwdata[47:0];
                REG_SPAN_L: r_span_l <= pwdata[47:0];
                REG_SPAN_G: r_span_g <= pwdata[47:0];
                REG_GCONC:  r_gconc  <= pwdata[VOL_W-1:0];
                REG_VMAX_I: r_vmax_i <= pwdata[VOL_W-1:0];
                REG_VMAX_L: r_vmax_l <= pwdata[VOL_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_reg)
            REG_GAIN:   prdata = PDATA_W'(r_gain);
            REG_REST:   prdata = PDATA_W'(r_rest);
            REG_SPAN_I: prdata = PDATA_W'(r_span_i);
            REG_SPAN_L: prdata = PDATA_W'(r_span_l);
            REG_SPAN_G: prdata = PDATA_W'(r_span_g);
            REG_GCONC:  prdata = PDATA_W'(r_gconc);
            REG_VMAX_I: prdata = PDATA_W'(r_vmax_i);
            REG_VMAX_L: prdata = PDATA_W'(r_vmax_l);
        endcase
    end

    // Saturate a widened sum to the DATA_WIDTH signed range.
    function automatic logic [W-1:0] f_sat(input logic signed [AW:0] x);
        if (x > MAXW) begin
            return MAXW[W-1:0];
        end else if (x < MINW) begin
            return MINW[W-1:0];
        end
        return x[W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Sequencer state and working registers
    // ------------------------------------------------------------------
    t_state r_state;
    t_state n_state;
    t_step  r_step;
    t_step  n_step;

    logic [CW-1:0]       r_idx;
    logic [CHAN_W-1:0]   r_chan;
    logic [SAMPLE_W-1:0] r_sample;
    logic [W-1:0] r_rp, r_pi, r_pl, r_pg, r_vi, r_vl, r_ci, r_cl, r_t1, r_t2;

    // per-channel stores
    logic [W-1:0] m_vi [NUM_CHANNELS];
    logic [W-1:0] m_vl [NUM_CHANNELS];
    logic [W-1:0] m_ci [NUM_CHANNELS];
    logic [W-1:0] m_cl [NUM_CHANNELS];

    logic            r_out_valid;
    logic [CHAN_W-1:0] r_out_chan;
    logic [PROB_W-1:0] r_out_prob;

    logic        w_in_acc;
    logic        w_chan_ok;
    logic [CW-1:0] w_idx;
    logic        w_out_free;
    t_uop        w_uop;
    logic signed [AW-1:0] w_a;
    logic signed [AW-1:0] w_b;
    logic signed [AW:0]   w_sum;
    logic [W-1:0] w_alu;
    logic [W-1:0] w_wval;
    logic        w_wen;
    logic        w_mul_go;
    logic        w_div_go;
    logic        w_mul_done;
    logic        w_div_done;
    logic        w_unit_done;
    logic [W-1:0] w_mul_res;
    logic [W-1:0] w_div_res;
    logic signed [AW:0]   w_t1x;
    logic [PROB_W-1:0]    w_prob;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_chan_ok  = ({5'b0, i_channel} < 9'(NUM_CHANNELS));
    assign w_idx      = CW'(i_channel);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_uop      = UPROG[r_step];

    function automatic logic signed [AW-1:0] f_src(input t_src s);
        unique case (s)
            SRC_ZERO:   return '0;
            SRC_SAMPLE: return AW'($signed(r_sample));
            SRC_GAIN:   return AW'($signed(r_gain));
            SRC_REST:   return AW'(r_rest);
            SRC_SPAN_I: return AW'($signed(r_span_i));
            SRC_SPAN_L: return AW'($signed(r_span_l));
            SRC_SPAN_G: return AW'($signed(r_span_g));
            SRC_GCONC:  return AW'(r_gconc);
            SRC_VMAX_I: return AW'(r_vmax_i);
            SRC_VMAX_L: return AW'(r_vmax_l);
            SRC_RP:     return AW'($signed(r_rp));
            SRC_PI:     return AW'($signed(r_pi));
            SRC_PL:     return AW'($signed(r_pl));
            SRC_PG:     return AW'($signed(r_pg));
            SRC_VI:     return AW'($signed(r_vi));
            SRC_VL:     return AW'($signed(r_vl));
            SRC_CI:     return AW'($signed(r_ci));
            SRC_CL:     return AW'($signed(r_cl));
            SRC_T1:     return AW'($signed(r_t1));
            SRC_T2:     return AW'($signed(r_t2));
            default:    return '0;
        endcase
    endfunction

    assign w_a = f_src(w_uop.a);
    assign w_b = f_src(w_uop.b);

    // Saturating add/subtract; ADDF also floors the result at zero.
    always_comb begin
        if (w_uop.op == OP_SUB) begin
            w_sum = (AW+1)'(w_a) - (AW+1)'(w_b);
        end else begin
            w_sum = (AW+1)'(w_a) + (AW+1)'(w_b);
        end
        w_alu = f_sat(w_sum);
        if (w_uop.op == OP_ADDF && w_alu[W-1]) begin
            w_alu = '0;
        end
    end

    assign w_mul_go    = (r_state == S_EXEC) && (w_uop.op == OP_MUL);
    assign w_div_go    = (r_state == S_EXEC) && (w_uop.op == OP_DIV);
    assign w_unit_done = (w_uop.op == OP_DIV) ? w_div_done : w_mul_done;

    always_comb begin
        w_wen  = 1'b0;
        w_wval = w_alu;
        if (r_state == S_EXEC) begin
            w_wen = !(w_uop.op == OP_MUL || w_uop.op == OP_DIV);
        end else if (r_state == S_WAIT) begin
            w_wen  = w_unit_done;
            w_wval = (w_uop.op == OP_DIV) ? w_div_res : w_mul_res;
        end
    end

    ihcs_mul #(.AW(AW), .W(W)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_go),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_done  (w_mul_done),
        .o_res   (w_mul_res)
    );

    ihcs_div #(.AW(AW), .W(W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_go),
        .i_n     (w_a),
        .i_d     (w_b),
        .o_done  (w_div_done),
        .o_res   (w_div_res)
    );

    // Advance through the micro-program; a step either finishes in S_EXEC
    // on the adder or waits in S_WAIT on the multiplier or divider.
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            S_IDLE: begin
                n_step = '0;
                if (w_in_acc && w_chan_ok && !i_func) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (w_uop.op == OP_MUL || w_uop.op == OP_DIV) begin
                    n_state = S_WAIT;
                end else if (r_step == LAST_STEP) begin
                    n_state = S_DONE;
                end else begin
                    n_step = r_step + t_step'(1);
                end
            end
            S_WAIT: begin
                if (w_unit_done) begin
                    if (r_step == LAST_STEP) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_EXEC;
                        n_step  = r_step + t_step'(1);
                    end
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // Latch the request, fetch channel state, and write back results.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_idx    <= w_idx;
            r_chan   <= i_channel;
            r_sample <= i_sample;
        end
        if (r_state == S_FETCH) begin
            r_vi <= m_vi[r_idx];
            r_vl <= m_vl[r_idx];
            r_ci <= m_ci[r_idx];
            r_cl <= m_cl[r_idx];
        end else if (w_wen) begin
            unique case (w_uop.dst)
                DST_RP:  r_rp <= w_wval;
                DST_PI:  r_pi <= w_wval;
                DST_PL:  r_pl <= w_wval;
                DST_PG:  r_pg <= w_wval;
                DST_VI:  r_vi <= w_wval;
                DST_VL:  r_vl <= w_wval;
                DST_CI:  r_ci <= w_wval;
                DST_CL:  r_cl <= w_wval;
                DST_T1:  r_t1 <= w_wval;
                DST_T2:  r_t2 <= w_wval;
                default: r_t2 <= w_wval;
            endcase
        end
    end

    // Stores: load requests write directly, sample requests write back at
    // the end of the step.
    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_chan_ok && i_func) begin
            m_vi[w_idx] <= f_sat((AW+1)'(i_init_immediate_volume));
            m_vl[w_idx] <= f_sat((AW+1)'(i_init_local_volume));
            m_ci[w_idx] <= f_sat((AW+1)'($signed(i_init_immediate_conc)));
            m_cl[w_idx] <= f_sat((AW+1)'($signed(i_init_local_conc)));
        end else if (r_state == S_DONE && w_out_free) begin
            m_vi[r_idx] <= r_vi;
            m_vl[r_idx] <= r_vl;
            m_ci[r_idx] <= r_ci;
            m_cl[r_idx] <= r_cl;
        end
    end

    // ------------------------------------------------------------------
    // Output register: clamp the probability to 48 bits
    // ------------------------------------------------------------------
    assign w_t1x = (AW+1)'($signed(r_t1));

    always_comb begin
        if (w_t1x > MAXP) begin
            w_prob = MAXP[PROB_W-1:0];
        end else if (w_t1x < MINP) begin
            w_prob = MINP[PROB_W-1:0];
        end else begin
            w_prob = w_t1x[PROB_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_out_chan <= r_chan;
            r_out_prob <= w_prob;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_channel = r_out_chan;
    assign o_spike_prob  = r_out_prob;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_unit_start_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mul_go || w_div_go) |=> (r_state == S_WAIT))
        else $error("unit started without entering wait");

    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (r_step == LAST_STEP))
        else $error("step finished before the last micro-op");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result raised outside completion");

    a_no_overlap_units: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mul_done && w_div_done))
        else $error("multiplier and divider finished together");

endmodule

@@ bench/ihc_synapse_reservoir_step_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ihc_synapse_reservoir_step_checker
// Watches the request, result and register ports of the synapse step, keeps
// its own copy of the registers and channel stores, predicts each spike
// probability and compares it with the result that the block returns.
// ----------------------------------------------------------------------------
module ihc_synapse_reservoir_step_checker import ihcs_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic                       i_func,
    input  logic        [CHAN_W-1:0]   i_channel,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic        [VOL_W-1:0]    i_init_immediate_volume,
    input  logic        [VOL_W-1:0]    i_init_local_volume,
    input  logic signed [CONC_W-1:0]   i_init_immediate_conc,
    input  logic signed [CONC_W-1:0]   i_init_local_conc,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic        [CHAN_W-1:0]   i_out_channel,
    input  logic signed [PROB_W-1:0]   i_spike_prob,
    input  logic                       i_psel,
    input  logic                       i_penable,
    input  logic                       i_pwrite,
    input  logic                       i_pready,
    input  logic        [PADDR_W-1:0]  i_paddr,
    input  logic        [PDATA_W-1:0]  i_pwdata,
    output int                         o_errors,
    output int                         o_pending
);

    typedef logic signed [47:0]  t_q;
    typedef logic signed [129:0] t_wide;

    typedef struct {
        logic [CHAN_W-1:0] chan;
        t_q                prob;
    } t_prob;

    localparam t_q QMAX = 48'sh7FFF_FFFF_FFFF;
    localparam t_q QMIN = 48'sh8000_0000_0000;

    t_q gain, rest, span_i, span_l, span_g, gconc, vmax_i, vmax_l;
    t_q vol_i [16];
    t_q vol_l [16];
    t_q conc_i [16];
    t_q conc_l [16];
    t_prob probs_due [$];

    function automatic t_q sat(input t_wide x);
        if (x > t_wide'(QMAX)) return QMAX;
        if (x < t_wide'(QMIN)) return QMIN;
        return t_q'(x);
    endfunction

    function automatic t_q qadd(input t_q a, input t_q b);
        t_wide wa, wb;
        wa = a;
        wb = b;
        return sat(wa + wb);
    endfunction

    function automatic t_q qsub(input t_q a, input t_q b);
        t_wide wa, wb;
        wa = a;
        wb = b;
        return sat(wa - wb);
    endfunction

    // Truncate the scaled product toward zero, then saturate.
    function automatic t_q qmul(input t_q a, input t_q b);
        t_wide wa, wb, p, m;
        wa = a;
        wb = b;
        p = wa * wb;
        m = (p < 0) ? -p : p;
        m = m >>> FRAC;
        return sat((p < 0) ? -m : m);
    endfunction

    // Divide by a volume; zero divisor saturates toward the numerator sign.
    function automatic t_q qdiv(input t_q n, input t_q d);
        t_wide nm, dm, q;
        if (d == 0) return (n > 0) ? QMAX : ((n < 0) ? QMIN : t_q'(0));
        nm = n;
        dm = d;
        nm = (nm < 0) ? -nm : nm;
        dm = (dm < 0) ? -dm : dm;
        q = (nm <<< FRAC) / dm;
        return sat(((n < 0) != (d < 0)) ? -q : q);
    endfunction

    function automatic t_q floor0(input t_q x);
        return (x < 0) ? t_q'(0) : x;
    endfunction

    function automatic t_prob synapse_step(input logic [CHAN_W-1:0] ch,
                                           input logic signed [SAMPLE_W-1:0] smp);
        t_q rp, pi, pl, pg, rpc, vi, vl, ci, cl, num;
        t_prob r;
        rp = qmul(t_q'(smp), gain);
        pi = floor0(qadd(qmul(span_i, rp), rest));
        pl = floor0(qadd(qmul(span_l, rp), rest));
        pg = floor0(qadd(qmul(span_g, rp), rest));
        rpc = floor0(rp);
        vi = qadd(vol_i[ch], qmul(qsub(vmax_i, vol_i[ch]), rpc));
        vl = qadd(vol_l[ch], qmul(qsub(vmax_l, vol_l[ch]), rpc));
        ci = conc_i[ch];
        cl = conc_l[ch];
        num = qsub(qmul(pl, qsub(cl, ci)), qmul(pi, ci));
        ci = qadd(ci, qdiv(num, vi));
        // local update sees the new immediate concentration
        num = qsub(qmul(pg, qsub(gconc, cl)), qmul(pl, qsub(cl, ci)));
        cl = qadd(cl, qdiv(num, vl));
        vol_i[ch] = vi;
        vol_l[ch] = vl;
        conc_i[ch] = ci;
        conc_l[ch] = cl;
        r.chan = ch;
        r.prob = qmul(ci, pi);
        return r;
    endfunction

    assign o_pending = probs_due.size();

    always @(posedge i_clk) begin
        t_prob exp_p;
        if (!i_rst_n) begin
            gain   <= 48'sd16777216;
            rest   <= '0;
            span_i <= '0;
            span_l <= '0;
            span_g <= '0;
            gconc  <= '0;
            vmax_i <= 48'sd16777216;
            vmax_l <= 48'sd16777216;
            o_errors <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[5:3]))
                    REG_GAIN:   gain   <= t_q'(i_pwdata[47:0]);
                    REG_REST:   rest   <= t_q'({1'b0, i_pwdata[46:0]});
                    REG_SPAN_I: span_i <= t_q'(i_pwdata[47:0]);
                    REG_SPAN_L: span_l <= t_q'(i_pwdata[47:0]);
                    REG_SPAN_G: span_g <= t_q'(i_pwdata[47:0]);
                    REG_GCONC:  gconc  <= t_q'({1'b0, i_pwdata[46:0]});
                    REG_VMAX_I: vmax_i <= t_q'({1'b0, i_pwdata[46:0]});
                    REG_VMAX_L: vmax_l <= t_q'({1'b0, i_pwdata[46:0]});
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_func) begin
                    vol_i[i_channel]  = t_q'({1'b0, i_init_immediate_volume});
                    vol_l[i_channel]  = t_q'({1'b0, i_init_local_volume});
                    conc_i[i_channel] = i_init_immediate_conc;
                    conc_l[i_channel] = i_init_local_conc;
                end else begin
                    probs_due.push_back(synapse_step(i_channel, i_sample));
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (probs_due.size() == 0) begin
                    $display("%0t: unexpected result ch %0d prob %0d", $time,
                             i_out_channel, i_spike_prob);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_p = probs_due.pop_front();
                    if (exp_p.chan !== i_out_channel || exp_p.prob !== i_spike_prob) begin
                        $display("%0t: mismatch expected ch %0d prob %0d, got ch %0d prob %0d",
                                 $time, exp_p.chan, exp_p.prob, i_out_channel, i_spike_prob);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

@@ bench/ihc_synapse_reservoir_step_top_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ihc_synapse_reservoir_step_top_test
// Drives load and sample requests with random bursts and result stalls
// through several register settings; the checker predicts and compares.
// ----------------------------------------------------------------------------
module ihc_synapse_reservoir_step_top_test;
    import ihcs_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int SETTLE      = 800;    // idle time after the final drain

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic                       i_func = 1'b0;
    logic        [CHAN_W-1:0]   i_channel = '0;
    logic signed [SAMPLE_W-1:0] i_sample = '0;
    logic        [VOL_W-1:0]    i_init_immediate_volume = '0;
    logic        [VOL_W-1:0]    i_init_local_volume = '0;
    logic signed [CONC_W-1:0]   i_init_immediate_conc = '0;
    logic signed [CONC_W-1:0]   i_init_local_conc = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic        [CHAN_W-1:0]   o_out_channel;
    logic signed [PROB_W-1:0]   o_spike_prob;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic        [PADDR_W-1:0]  paddr = '0;
    logic        [PDATA_W-1:0]  pwdata = '0;
    logic        [PDATA_W-1:0]  prdata;
    logic                       pready;

    int errors, pending;
    int cycles = 0;
    int burst_left = 0;
    int n_samples = 0, n_loads = 0, n_settings = 0;
    bit hold_start = 1'b0;
    int hold_left = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    ihc_synapse_reservoir_step_top dut (.*);

    ihc_synapse_reservoir_step_checker checker_i (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_stall(o_in_stall), .i_func, .i_channel,
        .i_sample, .i_init_immediate_volume, .i_init_local_volume,
        .i_init_immediate_conc, .i_init_local_conc, .i_out_valid(o_out_valid),
        .i_out_stall, .i_out_channel(o_out_channel), .i_spike_prob(o_spike_prob),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata), .o_errors(errors), .o_pending(pending)
    );

    // Bound the run; a hang here means results went missing.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("ihc_synapse_reservoir_step_top verification failed");
            $finish;
        end
    end

    // Receiver: stall on a randomly chosen pattern, or hold off completely
    // for a long stretch when asked.
    always @(negedge i_clk) begin
        int mode;
        if (hold_start) begin
            hold_left = 3000;
            hold_start = 1'b0;
        end
        if (cycles % 256 == 0) mode = $urandom_range(0, 3);
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            case (mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                2: i_out_stall <= ($urandom_range(0, 3) != 0);
                default: i_out_stall <= cycles[0];
            endcase
        end
    end

    // Mix of extremes and moderate values around 1.0 in Q.24.
    function automatic logic [47:0] pick48();
        logic signed [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 6))
            0: return 48'h0;
            1: return 48'h7FFF_FFFF_FFFF;
            2: return 48'h8000_0000_0000;
            3: return 48'({$urandom, $urandom});
            4: return 48'(r >>> 6);
            default: return 48'(r >>> 8) + 48'h100_0000;
        endcase
    endfunction

    task automatic reg_write(input t_reg_idx idx, input logic [47:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx) << 3;
        pwdata  <= {{16{val[47]}}, val};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Offer one request; hold it until taken, then maybe open a gap.
    task automatic send_req(input logic fn, input logic [CHAN_W-1:0] ch,
                            input logic [31:0] smp, input logic [47:0] vi,
                            input logic [47:0] vl, input logic [47:0] ci,
                            input logic [47:0] cl);
        int gap;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_func <= fn;
        i_channel <= ch;
        i_sample <= smp;
        i_init_immediate_volume <= vi[46:0];
        i_init_local_volume <= vl[46:0];
        i_init_immediate_conc <= ci;
        i_init_local_conc <= cl;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        if (fn) n_loads++; else n_samples++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 8);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    endtask

    task automatic send_random(input int count);
        repeat (count) begin
            if ($urandom_range(0, 3) == 0)
                send_req(1'b1, 4'($urandom), $urandom, pick48(), pick48(), pick48(),
                         pick48());
            else
                send_req(1'b0, 4'($urandom), $urandom, pick48(), pick48(), pick48(),
                         pick48());
        end
    endtask

    // Drop valid and wait for every expected result, then let the block settle.
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_all(input logic [47:0] g, input logic [47:0] r,
                           input logic [47:0] si, input logic [47:0] sl,
                           input logic [47:0] sg, input logic [47:0] gc,
                           input logic [47:0] mi, input logic [47:0] ml);
        reg_write(REG_GAIN, g);
        reg_write(REG_REST, r);
        reg_write(REG_SPAN_I, si);
        reg_write(REG_SPAN_L, sl);
        reg_write(REG_SPAN_G, sg);
        reg_write(REG_GCONC, gc);
        reg_write(REG_VMAX_I, mi);
        reg_write(REG_VMAX_L, ml);
        n_settings++;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Load every channel before any sample reads it; extremes on 0 and 15.
        for (int c = 0; c < 16; c++)
            send_req(1'b1, 4'(c), 32'h0, 48'h100_0000, 48'h80_0000, 48'h10_0000,
                     48'h20_0000);
        send_req(1'b1, 4'd15, 32'h0, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF,
                 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000);
        send_req(1'b0, 4'd15, 32'h7FFF_FFFF, '0, '0, '0, '0);
        send_req(1'b0, 4'd0, 32'h8000_0000, '0, '0, '0, '0);
        send_req(1'b0, 4'd1, 32'h0, '0, '0, '0, '0);
        drain();

        // Zero volumes with a negative release factor: divide by zero.
        set_all(48'h100_0000, 48'h4_0000, 48'h10_0000, 48'h8_0000, 48'h2_0000,
                48'h80_0000, 48'h0, 48'h0);
        send_req(1'b1, 4'd2, 32'h0, 48'h0, 48'h0, 48'h100_0000, 48'hFF_FF00_0000);
        send_req(1'b0, 4'd2, 32'hFF00_0000, '0, '0, '0, '0);
        send_req(1'b1, 4'd3, 32'h0, 48'h0, 48'h0, 48'h0, 48'h0);
        send_req(1'b0, 4'd3, 32'hFF00_0000, '0, '0, '0, '0);
        drain();
        // Volume above its maximum with a large gain overshoots below zero.
        reg_write(REG_GAIN, 48'h400_0000);
        send_req(1'b1, 4'd4, 32'h0, 48'h300_0000, 48'h300_0000, 48'h100_0000,
                 48'h100_0000);
        send_req(1'b0, 4'd4, 32'h100_0000, '0, '0, '0, '0);
        send_req(1'b0, 4'd4, 32'h100_0000, '0, '0, '0, '0);
        drain();

        // Extremes of every register, both ends.
        set_all(48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF,
                48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF,
                48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF);
        send_random(30);
        drain();
        set_all(48'h8000_0000_0000, 48'h0, 48'h8000_0000_0000, 48'h8000_0000_0000,
                48'h8000_0000_0000, 48'h0, 48'h0, 48'h0);
        send_random(30);
        drain();

        // Long receiver hold-off while requests keep coming: block fills up.
        hold_start = 1'b1;
        send_random(10);

        // Random phases, each with a fresh register setting.
        for (int ph = 0; ph < 8; ph++) begin
            drain();
            set_all(pick48(), pick48(), pick48(), pick48(), pick48(), pick48(),
                    pick48(), pick48());
            send_random(110);
        end
        drain();
        repeat (SETTLE) @(posedge i_clk);

        $display("covered %0d sample and %0d load requests over %0d register settings",
                 n_samples, n_loads, n_settings);
        if (errors == 0)
            $display("ihc_synapse_reservoir_step_top verification clean");
        else
            $display("ihc_synapse_reservoir_step_top verification failed");
        $finish;
    end

endmodule
